// ----- rtl/divide_reciprocal_magic_finder_defines.svh -----
// Assertion macros shared by the reciprocal finder RTL.
// Needs i_clk and i_rst_n in the module that uses them.
`ifndef DIVIDE_RECIPROCAL_MAGIC_FINDER_DEFINES_SVH
`define DIVIDE_RECIPROCAL_MAGIC_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DRMF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Next-cycle implication.
`define DRMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRMF_ASSERT(label, prop, msg)
`define DRMF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/drmf_pkg.sv -----
// Package for the reciprocal finder: widths, constants, sequencer states
// and the divider request/response types. No dependencies.
package drmf_pkg;

    localparam int DataW     = 32;
    localparam int RecipW    = 32;
    localparam int ShiftW    = 6;
    localparam int LogW      = 5;
    localparam int DivNumW   = 62;
    localparam int DivDenW   = 31;
    localparam int DivCntW   = $clog2(DivNumW + 1);
    localparam int ProdW     = DivDenW + RecipW;
    localparam int OutDataW  = 40;

    localparam int ShiftBase = 30;
    localparam logic [DivDenW-1:0] TopDividend = 31'h7FFF_FFFF;
    localparam logic [DivDenW-1:0] WideMargin  = 31'd10;
    localparam logic [DivDenW-1:0] WideCount   = 31'd20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOG,
        S_RDIV,
        S_RWAIT,
        S_TDIV,
        S_TWAIT,
        S_CHK,
        S_CWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic               wide;
        logic [DivNumW-1:0] num;
        logic [DivDenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DivNumW-1:0] quo;
        logic [DivDenW-1:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/divide_reciprocal_magic_finder.sv -----
// Top level of the reciprocal finder: sequencer around one shared divider.
// Depends on drmf_pkg, drmf_div and the assertion macro header.
`include "divide_reciprocal_magic_finder_defines.svh"

// Finds a multiply-shift reciprocal for division by an invariant positive divisor.
// Each input word carries a signed 32-bit divisor d; each output word carries status,
// reciprocal r and shift s with s = 30 + ceil(log2 d) and r = ceil(2^s / d). A divisor
// of zero or below gives status 1 with r and s zero. The pair is then verified on a
// window of dividends just below 2^31-1 (twenty values ending ten above the last
// multiple of d when the remainder of 2^31-1 by d exceeds ten, otherwise down to
// 2^31-1 - 2d); a wrong quotient anywhere in the window forces r to zero while
// status stays 0. One divisor is handled at a time and o_s_tready is high only
// while the sequencer idles. Steps per word: a non-positive divisor goes straight
// to the output; otherwise a log search (one power-of-two compare a cycle), the
// 62-bit reciprocal division, 2^31-1 divided by d, and one division for every
// quotient block visited in the window (none when the narrow window is empty,
// otherwise one to three). Each division runs on the shared radix-2 divider, which
// retires one quotient bit per cycle. A finished word waits in the output register
// and the next divisor is accepted meanwhile.
module divide_reciprocal_magic_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] divisor (signed)
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [0] status, [32:1] reciprocal, [38:33] shift_amount
);

    localparam int DenW  = drmf_pkg::DivDenW;
    localparam int NumW  = drmf_pkg::DivNumW;
    localparam int RecW  = drmf_pkg::RecipW;
    localparam int ShW   = drmf_pkg::ShiftW;
    localparam int LogW  = drmf_pkg::LogW;
    localparam int ProdW = drmf_pkg::ProdW;
    localparam int DatW  = drmf_pkg::DataW;

    drmf_pkg::t_state r_state, n_state;

    logic [DenW-1:0]  r_d, n_d;          // positive divisor
    logic [DatW-1:0]  r_pow, n_pow;      // 2^c during the log search
    logic [LogW-1:0]  r_c, n_c;          // ceil(log2 d)
    logic [RecW-1:0]  r_r, n_r;          // candidate reciprocal
    logic             r_err, n_err;
    logic [DenW-1:0]  r_n, n_n;          // dividend under check
    logic [DenW-1:0]  r_low, n_low;      // window floor, exclusive
    logic [ProdW-1:0] r_prod, n_prod;    // n * r

    logic             r_m_valid, n_m_valid;
    logic             r_status, n_status;
    logic [RecW-1:0]  r_recip, n_recip;
    logic [ShW-1:0]   r_shift, n_shift;

    drmf_pkg::t_div_req w_req;
    drmf_pkg::t_div_rsp w_rsp;

    logic [ShW-1:0]   w_s;
    logic [DenW:0]    w_twice;
    logic [DenW-1:0]  w_top;
    logic [ProdW-1:0] w_est;

    assign w_s     = ShW'(r_c) + ShW'(drmf_pkg::ShiftBase);
    assign w_twice = {r_d, 1'b0};
    assign w_est   = r_prod >> w_s;

    drmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_d       = r_d;
        n_pow     = r_pow;
        n_c       = r_c;
        n_r       = r_r;
        n_err     = r_err;
        n_n       = r_n;
        n_low     = r_low;
        n_prod    = r_prod;
        n_m_valid = r_m_valid && !i_m_tready;
        n_status  = r_status;
        n_recip   = r_recip;
        n_shift   = r_shift;
        w_top     = '0;

        w_req.start = 1'b0;
        w_req.wide  = 1'b0;
        w_req.num   = '0;
        w_req.den   = r_d;

        o_s_tready = (r_state == drmf_pkg::S_IDLE);

        unique case (r_state)
            drmf_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    // zero or sign bit set: not positive, report at once
                    if (i_s_tdata == '0 || i_s_tdata[DatW-1]) begin
                        n_err   = 1'b1;
                        n_state = drmf_pkg::S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_d     = i_s_tdata[DenW-1:0];
                        n_pow   = DatW'(1);
                        n_c     = '0;
                        n_state = drmf_pkg::S_LOG;
                    end
                end
            end
            drmf_pkg::S_LOG: begin
                // advance while 2^c is still below d
                if (r_pow < {1'b0, r_d}) begin
                    n_pow = {r_pow[DatW-2:0], 1'b0};
                    n_c   = r_c + LogW'(1);
                end else begin
                    n_state = drmf_pkg::S_RDIV;
                end
            end
            drmf_pkg::S_RDIV: begin
                // ceil(2^s / d) as floor((2^s + d - 1) / d)
                w_req.start = 1'b1;
                w_req.wide  = 1'b1;
                w_req.num   = (NumW'(1) << w_s) + NumW'(r_d) - NumW'(1);
                n_state     = drmf_pkg::S_RWAIT;
            end
            drmf_pkg::S_RWAIT: begin
                if (w_rsp.done) begin
                    n_r = w_rsp.quo[RecW-1:0];
                    if (w_rsp.quo[NumW-1:RecW] != '0) begin
                        n_err   = 1'b1;
                        n_state = drmf_pkg::S_DONE;
                    end else begin
                        n_state = drmf_pkg::S_TDIV;
                    end
                end
            end
            drmf_pkg::S_TDIV: begin
                w_req.start = 1'b1;
                w_req.num   = NumW'(drmf_pkg::TopDividend);
                n_state     = drmf_pkg::S_TWAIT;
            end
            drmf_pkg::S_TWAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.rem > drmf_pkg::WideMargin) begin
                        // wide window: twenty values from the last multiple plus margin
                        w_top = drmf_pkg::TopDividend - w_rsp.rem + drmf_pkg::WideMargin;
                        n_n   = w_top;
                        n_low = w_top - drmf_pkg::WideCount;
                    end else begin
                        n_n = drmf_pkg::TopDividend;
                        if (w_twice > {1'b0, drmf_pkg::TopDividend}) begin
                            n_low = drmf_pkg::TopDividend;
                        end else begin
                            n_low = DenW'({1'b0, drmf_pkg::TopDividend} - w_twice);
                        end
                    end
                    n_state = drmf_pkg::S_CHK;
                end
            end
            drmf_pkg::S_CHK: begin
                if (r_n > r_low) begin
                    w_req.start = 1'b1;
                    w_req.num   = NumW'(r_n);
                    n_prod      = ProdW'(r_n) * ProdW'(r_r);
                    n_state     = drmf_pkg::S_CWAIT;
                end else begin
                    n_state = drmf_pkg::S_DONE;
                end
            end
            drmf_pkg::S_CWAIT: begin
                if (w_rsp.done) begin
                    if (w_est != ProdW'(w_rsp.quo)) begin
                        // wrong quotient: drop the reciprocal, keep status ok
                        n_r     = '0;
                        n_state = drmf_pkg::S_DONE;
                    end else if (w_rsp.quo == '0) begin
                        n_state = drmf_pkg::S_DONE;
                    end else begin
                        // step to the last dividend of the previous quotient block
                        n_n     = r_n - w_rsp.rem - DenW'(1);
                        n_state = drmf_pkg::S_CHK;
                    end
                end
            end
            drmf_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_status  = r_err;
                    n_recip   = r_err ? '0 : r_r;
                    n_shift   = r_err ? '0 : w_s;
                    n_state   = drmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drmf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drmf_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_err     <= n_err;
        end
        r_d      <= n_d;
        r_pow    <= n_pow;
        r_c      <= n_c;
        r_r      <= n_r;
        r_n      <= n_n;
        r_low    <= n_low;
        r_prod   <= n_prod;
        r_status <= n_status;
        r_recip  <= n_recip;
        r_shift  <= n_shift;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_shift, r_recip, r_status};

    `DRMF_ASSERT(a_err_fields_zero, (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[38:1] == '0), "error word with non-zero reciprocal or shift")
    `DRMF_ASSERT(a_ok_shift_range, (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[38:33] >= 6'd30 && o_m_tdata[38:33] <= 6'd61), "ok word with shift out of range")
    `DRMF_ASSERT_NEXT(a_accept_leaves_idle, i_s_tvalid && o_s_tready, r_state != drmf_pkg::S_IDLE, "accepted divisor left the sequencer idle")

endmodule

// ----- rtl/drmf_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on drmf_pkg and the assertion macro header.
`include "divide_reciprocal_magic_finder_defines.svh"

module drmf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drmf_pkg::t_div_req i_req,
    output drmf_pkg::t_div_rsp o_rsp
);

    localparam int NumW = drmf_pkg::DivNumW;
    localparam int DenW = drmf_pkg::DivDenW;
    localparam int CntW = drmf_pkg::DivCntW;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [NumW-1:0] r_num, n_num;
    logic [DenW-1:0] r_rem, n_rem;
    logic [DenW-1:0] r_den, n_den;

    logic [DenW:0]   w_trial;
    logic [DenW:0]   w_diff;
    logic            w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[NumW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;

        if (i_req.start) begin
            // narrow requests sit left-aligned so the quotient lands in the low bits
            n_busy = 1'b1;
            n_rem  = '0;
            n_den  = i_req.den;
            if (i_req.wide) begin
                n_cnt = CntW'(NumW);
                n_num = i_req.num;
            end else begin
                n_cnt = CntW'(DenW);
                n_num = {i_req.num[DenW-1:0], {(NumW-DenW){1'b0}}};
            end
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DenW-1:0] : w_trial[DenW-1:0];
            n_num = {r_num[NumW-2:0], w_ge};
            n_cnt = r_cnt - CntW'(1);
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
    assign o_rsp.rem  = r_rem;

    `DRMF_ASSERT(a_no_restart, i_req.start |-> !r_busy, "divider restarted while busy")
    `DRMF_ASSERT(a_rem_below_den, r_busy |-> (r_rem < r_den), "partial remainder not below divisor")
    `DRMF_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "divider done held for two cycles")

endmodule

// ----- bench/recip_result_check.sv -----
// Result checker for the reciprocal finder: watches both stream channels,
// predicts each result word and compares it. Depends on drmf_pkg.
`timescale 1ns / 1ps

module recip_result_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [drmf_pkg::DataW-1:0]   i_s_tdata,   // [31:0] divisor (signed)
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [drmf_pkg::OutDataW-1:0] i_m_tdata,  // [0] status, [32:1] recip, [38:33] shift
    output int                           o_pending,
    output int                           o_mismatches
);
    import drmf_pkg::*;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic              status;
        logic [RecipW-1:0] reciprocal;
        logic [ShiftW-1:0] shift;
    } recip_word_t;

    recip_word_t       recips_due [$];
    logic [DataW-1:0]  divisors_due [$];

    // Shift is 30 plus the exact ceiling log2 of d, multiplier is the rounded-up
    // quotient; then walk the window below 2^31-1, one dividend per quotient block.
    function automatic recip_word_t predict_recip(input logic [DataW-1:0] divisor);
        logic [63:0] d, r, q, top, low, n, m, limit;
        int unsigned lg, sh;
        logic        ok, walking;
        recip_word_t w;
        w.status     = STATUS_BAD;
        w.reciprocal = '0;
        w.shift      = '0;
        if (divisor == '0 || divisor[DataW-1])
            return w;
        d  = {32'd0, divisor};
        lg = 0;
        while (lg < 32 && (64'd1 << lg) < d)
            lg++;
        sh = ShiftBase + lg;
        r  = ((64'd1 << sh) + d - 64'd1) / d;
        if (r[63:32] != '0)
            return w;
        limit = {33'd0, TopDividend};
        q = (limit / d) * d + {33'd0, WideMargin};
        if (q < limit) begin
            top = q;
            low = q - {33'd0, WideCount};
        end else begin
            top = limit;
            low = (2 * d > limit) ? limit : limit - 2 * d;
        end
        ok      = 1'b1;
        walking = 1'b1;
        n       = top;
        while (walking && n > low) begin
            if (((n * r) >> sh) != n / d) begin
                ok      = 1'b0;
                walking = 1'b0;
            end else begin
                m = n % d;
                if (n < m + 64'd1)
                    walking = 1'b0;
                else
                    n = n - m - 64'd1;
            end
        end
        w.status     = STATUS_OK;
        w.reciprocal = ok ? r[31:0] : '0;
        w.shift      = sh[ShiftW-1:0];
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        recip_word_t      got, want;
        logic [DataW-1:0] divisor;
        logic             bad;
        bad = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                recips_due.push_back(predict_recip(i_s_tdata));
                divisors_due.push_back(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status     = i_m_tdata[0];
                got.reciprocal = i_m_tdata[32:1];
                got.shift      = i_m_tdata[38:33];
                if (recips_due.size() == 0) begin
                    $display("%0t: result word with no divisor outstanding: expected none, actual %h",
                             $time, i_m_tdata);
                    bad = 1'b1;
                end else begin
                    want    = recips_due.pop_front();
                    divisor = divisors_due.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: divisor %h status: expected %0d, actual %0d",
                                 $time, divisor, want.status, got.status);
                        bad = 1'b1;
                    end
                    if (got.reciprocal !== want.reciprocal) begin
                        $display("%0t: divisor %h reciprocal: expected %h, actual %h",
                                 $time, divisor, want.reciprocal, got.reciprocal);
                        bad = 1'b1;
                    end
                    if (got.shift !== want.shift) begin
                        $display("%0t: divisor %h shift: expected %0d, actual %0d",
                                 $time, divisor, want.shift, got.shift);
                        bad = 1'b1;
                    end
                end
            end
        end
        o_pending <= recips_due.size();
        if (bad)
            o_mismatches <= o_mismatches + 1;
    end

endmodule

// ----- bench/tb_divide_reciprocal_magic_finder.sv -----
// Testbench top for the reciprocal finder: clock, reset, divisor stimulus and
// result back-pressure. Depends on drmf_pkg, the block and recip_result_check.
`timescale 1ns / 1ps

module tb_divide_reciprocal_magic_finder;
    import drmf_pkg::*;

    localparam int unsigned RandomItems = 1030;
    // Allow many times the slowest word plus its gaps and stalls.
    localparam int unsigned CycleLimit  = 3_000_000;
    // Longest single word through the shared divider, with margin.
    localparam int unsigned TailCycles  = 400;
    localparam logic [DataW-1:0] TopValue = 32'h7FFF_FFFF;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [DataW-1:0]      i_s_tdata  = '0;   // [31:0] divisor (signed)
    logic                  i_m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OutDataW-1:0]   o_m_tdata;         // [0] status, [32:1] recip, [38:33] shift

    int                    words_pending;
    int                    mismatches;
    int unsigned           cycle_count = 0;

    // Sender pacing: words left in the current burst, and whether valid is already low.
    int unsigned           burst_left = 1;
    logic                  valid_low  = 1'b1;

    // Receiver pattern: current stall mode and cycles left in it.
    int unsigned           stall_mode = 0;
    int unsigned           mode_left  = 0;

    // Hand-picked divisors: non-positive values, tiny and huge divisors, powers of
    // two either side, both remainder windows with the boundary at ten, an empty
    // narrow window (2d above 2^31-1), the widest shift, and a divisor whose
    // multiplier fails the window check.
    logic [DataW-1:0] directed_divisors [$] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
        32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0007,
        32'h0000_000A, 32'h0000_000B, 32'h0000_0064, 32'h0000_03E8,
        32'h0000_FFFF, 32'h0001_0000, 32'h2AAA_AAAA, 32'h3FFF_FFFF,
        32'h4000_0000, 32'h4000_0001, 32'h5555_5555, 32'h7FFF_FFF4,
        32'h7FFF_FFF5, 32'h7FFF_FFFE, 32'h7FFF_FFFF
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    divide_reciprocal_magic_finder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    recip_result_check result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (words_pending),
        .o_mismatches (mismatches)
    );

    // Watchdog: give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result back-pressure: switch between always ready, coin-flip, rare ready and
    // a periodic stall, each for a random stretch of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 400);
            end else begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0: begin
                    i_m_tready <= 1'b1;
                end
                1: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_m_tready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    i_m_tready <= (cycle_count[2:0] != 3'd0);
                end
            endcase
        end
    end

    // Present one divisor and hold it until accepted; at the end of a burst drop
    // valid for a random gap, or carry straight on.
    task automatic feed_divisor(input logic [DataW-1:0] divisor);
        int unsigned gap;
        i_s_tdata  <= divisor;
        i_s_tvalid <= 1'b1;
        valid_low  = 1'b0;
        do @(posedge i_clk); while (!o_s_tready);
        if (burst_left > 0)
            burst_left = burst_left - 1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                valid_low  = 1'b1;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off the sender until every outstanding result word has come back.
    task automatic drain_results();
        if (!valid_low) begin
            i_s_tvalid <= 1'b0;
            valid_low  = 1'b1;
        end
        @(posedge i_clk);
        while (words_pending != 0)
            @(posedge i_clk);
    endtask

    // Mix of divisor shapes: non-positive, small, near powers of two, near
    // 2^31-1 over a small integer (remainder window boundaries), and random widths.
    function automatic logic [DataW-1:0] pick_divisor();
        logic [DataW-1:0] d;
        int unsigned      kind, k;
        kind = $urandom_range(0, 99);
        if (kind < 2) begin
            d = '0;
        end else if (kind < 8) begin
            d = {1'b1, 31'($urandom())};
        end else if (kind < 35) begin
            d = $urandom_range(1, 2000);
        end else if (kind < 55) begin
            k = $urandom_range(0, 31);
            d = (32'd1 << k) + 32'($urandom_range(0, 6)) - 32'd3;
        end else if (kind < 70) begin
            d = TopValue / $urandom_range(1, 64) + 32'($urandom_range(0, 20)) - 32'd10;
        end else begin
            d = $urandom() >> $urandom_range(0, 31);
        end
        return d;
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_divisors[i])
            feed_divisor(directed_divisors[i]);
        drain_results();

        for (int unsigned i = 0; i < RandomItems; i++) begin
            if (i == RandomItems / 2)
                drain_results();
            feed_divisor(pick_divisor());
        end

        drain_results();
        repeat (TailCycles) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
